[rtl/skts_pkg.sv]
// Shared types and codes for the sorted key table.
// No dependencies; imported by skts_ram, skts_ctrl and sorted_key_table_search.
package skts_pkg;

  localparam int ADDR_W       = 16;
  localparam int SMALL_WINDOW = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  localparam logic [1:0] METHOD_LINEAR = 2'd0;
  localparam logic [1:0] METHOD_BINARY = 2'd1;
  localparam logic [1:0] METHOD_INTERP = 2'd2;

  typedef struct packed {
    logic [31:0]        payload;
    logic signed [31:0] key;
  } mem_word_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    mem_word_t         wdata;
  } mem_cmd_t;

endpackage

[rtl/skts_ram.sv]
// Single-port record memory (key and payload), registered read data.
// Depends on skts_pkg for the command and word types.
module skts_ram #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  skts_pkg::mem_cmd_t   cmd,
  output skts_pkg::mem_word_t  rdata_r
);
  import skts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr[AW-1:0]] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[cmd.addr[AW-1:0]];
    end
  end

endmodule

[rtl/skts_div.sv]
// Restoring divider, one quotient bit per cycle, for the interpolation probe.
// Standalone; no package needed.
module skts_div #(
  parameter int NW = 41
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic          done_r,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   acc_r;
  logic [31:0]     rem_r;
  logic [31:0]     den_r;
  logic [32:0]     sh;
  logic [32:0]     dif;
  logic            ge;

  assign sh  = {rem_r, acc_r[NW-1]};
  assign dif = sh - {1'b0, den_r};
  assign ge  = (sh >= {1'b0, den_r});
  assign quo = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        acc_r <= {acc_r[NW-2:0], ge};
        rem_r <= ge ? dif[31:0] : sh[31:0];
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/skts_isqrt.sv]
// Integer square root, one root bit per cycle (digit-by-digit method).
// Standalone; no package needed.
module skts_isqrt #(
  parameter int RW = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] val,
  output logic            done_r,
  output logic [RW-1:0]   root_r
);
  localparam int CNTW = $clog2(RW + 1);

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [2*RW-1:0] val_r;
  logic [RW+1:0]   rem_r;
  logic [RW+1:0]   rem2;
  logic [RW+1:0]   trial;
  logic            ge;

  assign rem2  = {rem_r[RW-1:0], val_r[2*RW-1:2*RW-2]};
  assign trial = {root_r, 2'b01};
  assign ge    = (rem2 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        val_r  <= val;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNTW'(RW);
      end else if (busy_r) begin
        val_r  <= {val_r[2*RW-3:0], 2'b00};
        rem_r  <= ge ? (rem2 - trial) : rem2;
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/skts_ctrl.sv]
// Controller: operation sequencer, search state, result register.
// Depends on skts_pkg; drives skts_ram, skts_div and skts_isqrt.
module skts_ctrl #(
  parameter int CAPACITY = 256,
  parameter int CW       = 9,
  parameter int NW       = 41,
  parameter int RW       = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,
  output logic [1:0]          out_tuser,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  output skts_pkg::mem_cmd_t  mem_cmd,
  input  skts_pkg::mem_word_t mem_rdata,
  output logic                div_start,
  output logic [NW-1:0]       div_num,
  output logic [31:0]         div_den,
  input  logic                div_done,
  input  logic [NW-1:0]       div_quo,
  output logic                sq_start,
  output logic [2*RW-1:0]     sq_val,
  input  logic                sq_done,
  input  logic [RW-1:0]       sq_root
);
  import skts_pkg::*;

  localparam int IPW = CW + 1;
  localparam int SW  = RW + 3;
  localparam int GW  = $clog2(CAPACITY + 4);
  localparam logic signed [SW-1:0] POS_ONE   = SW'(1);
  localparam logic signed [SW-1:0] WIN_SMALL = SW'(SMALL_WINDOW);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_PUT, S_LIN_RD, S_LIN_CMP,
    S_PRE_HI, S_PRE_LO, S_PRE_CHK, S_BIN_RD, S_BIN_CMP,
    S_INT_WIN, S_INT_RL, S_INT_RR, S_INT_DIF, S_INT_DIV, S_INT_DWT,
    S_INT_NRD, S_INT_NCMP, S_STP_M1, S_STP_M2, S_STP_SQ, S_STP_SW,
    S_STP_RD, S_STP_CMP, S_SCAN_RD, S_SCAN_CMP, S_DEL_RD, S_DEL_WR, S_FIN
  } state_t;

  state_t                state_r;
  logic [1:0]            method_r;
  logic [CW-1:0]         count_r;
  mode_t                 mode_r;
  logic signed [31:0]    key_r;
  logic [31:0]           pay_in_r;
  logic signed [31:0]    khi_r;
  logic signed [31:0]    klo_r;
  logic signed [SW-1:0]  cur_r;
  logic signed [SW-1:0]  lo_r;
  logic signed [SW-1:0]  hi_r;
  logic signed [SW-1:0]  left_r;
  logic signed [SW-1:0]  right_r;
  logic signed [SW-1:0]  next_r;
  logic signed [SW-1:0]  temp_r;
  logic [CW-1:0]         size_r;
  logic [GW-1:0]         guard_r;
  logic                  up_r;
  logic [IPW-1:0]        i_r;
  logic [2*IPW-1:0]      isq_r;
  logic [2*RW-1:0]       prod_r;
  logic [RW-1:0]         prev_r;
  logic [RW-1:0]         root_r;
  logic [NW-1:0]         num_r;
  logic [31:0]           den_r;
  status_t               res_status_r;
  logic signed [SW-1:0]  res_idx_r;
  logic [31:0]           res_pay_r;
  logic                  out_valid_r;
  logic [55:0]           out_tdata_r;
  logic [1:0]            out_tuser_r;

  logic signed [SW-1:0]  n_s;
  logic signed [SW-1:0]  n_m1;
  logic signed [SW-1:0]  size_s;
  logic signed [SW-1:0]  lo_nxt;
  logic signed [SW-1:0]  hi_nxt;
  logic signed [SW-1:0]  temp_nxt;
  logic signed [SW-1:0]  root_s;
  logic signed [SW-1:0]  prev_s;
  logic [CW-1:0]         size_m1;
  logic signed [32:0]    diff_s;
  logic signed [32:0]    dvs_s;
  logic                  key_eq;
  logic                  key_gt;
  logic                  key_lt;
  logic [CW+8:0]         cnt_w;
  logic [SW+7:0]         idx_w;
  mode_t                 in_mode;
  logic signed [31:0]    in_key;

  function automatic logic [ADDR_W-1:0] to_addr(logic signed [SW-1:0] p);
    logic [SW+ADDR_W-1:0] w;
    w = {{ADDR_W{1'b0}}, p};
    return w[ADDR_W-1:0];
  endfunction

  assign in_mode = mode_t'(in_tuser);
  assign in_key  = $signed(in_tdata[31:0]);
  assign n_s     = $signed({{(SW-CW){1'b0}}, count_r});
  assign n_m1    = n_s - POS_ONE;
  assign size_s  = right_r - left_r + POS_ONE;
  assign size_m1 = size_r - CW'(1);
  assign root_s  = $signed({3'b000, sq_root});
  assign prev_s  = $signed({3'b000, prev_r});
  assign key_eq  = (mem_rdata.key == key_r);
  assign key_gt  = (key_r > $signed(mem_rdata.key));
  assign key_lt  = (key_r < $signed(mem_rdata.key));
  assign diff_s  = {key_r[31], key_r} - {klo_r[31], klo_r};
  assign dvs_s   = {mem_rdata.key[31], mem_rdata.key} - {klo_r[31], klo_r};

  // Binary search window update after a probe
  always_comb begin
    if ($signed(mem_rdata.key) < key_r) begin
      lo_nxt = cur_r + POS_ONE;
      hi_nxt = hi_r;
    end else begin
      lo_nxt = lo_r;
      hi_nxt = cur_r - POS_ONE;
    end
  end

  // Jump target, clamped to the table
  always_comb begin
    if (up_r) begin
      temp_nxt = next_r + root_s;
      if (temp_nxt > n_m1) begin
        temp_nxt = n_m1;
      end
    end else begin
      temp_nxt = next_r - root_s;
      if (temp_nxt < 0) begin
        temp_nxt = '0;
      end
    end
  end

  always_comb begin
    mem_cmd       = '0;
    mem_cmd.wdata = mem_rdata;
    case (state_r)
      S_INS_RD: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(cur_r - POS_ONE);
      end
      S_INS_CMP: begin
        mem_cmd.wr   = key_lt;
        mem_cmd.addr = to_addr(cur_r);
      end
      S_INS_PUT: begin
        mem_cmd.wr            = 1'b1;
        mem_cmd.addr          = to_addr(cur_r);
        mem_cmd.wdata.key     = key_r;
        mem_cmd.wdata.payload = pay_in_r;
      end
      S_LIN_RD, S_BIN_RD, S_SCAN_RD: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(cur_r);
      end
      S_PRE_HI: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(n_m1);
      end
      S_PRE_LO: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = '0;
      end
      S_INT_RL: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(left_r);
      end
      S_INT_RR: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(right_r);
      end
      S_INT_NRD: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(next_r);
      end
      S_STP_RD: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(temp_r);
      end
      S_DEL_RD: begin
        mem_cmd.rd   = 1'b1;
        mem_cmd.addr = to_addr(cur_r + POS_ONE);
      end
      S_DEL_WR: begin
        mem_cmd.wr   = 1'b1;
        mem_cmd.addr = to_addr(cur_r);
      end
      default: begin
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign div_start  = (state_r == S_INT_DIV);
  assign div_num    = num_r;
  assign div_den    = den_r;
  assign sq_start   = (state_r == S_STP_SQ);
  assign sq_val     = prod_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign cnt_w      = {9'b0, count_r};
  assign idx_w      = {8'b0, res_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      method_r    <= METHOD_LINEAR;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        method_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r    <= in_mode;
            key_r     <= in_key;
            pay_in_r  <= in_tdata[63:32];
            res_idx_r <= '0;
            res_pay_r <= '0;
            case (in_mode)
              MODE_INSERT: begin
                cur_r        <= n_s;
                res_status_r <= (count_r == CW'(CAPACITY)) ? STAT_FULL : STAT_OK;
                if (count_r == CW'(CAPACITY)) begin
                  state_r <= S_FIN;
                end else if (count_r != '0) begin
                  state_r <= S_INS_RD;
                end else begin
                  state_r <= S_INS_PUT;
                end
              end
              MODE_DELETE, MODE_LOOKUP: begin
                cur_r        <= '0;
                res_status_r <= (count_r == '0) ? STAT_EMPTY : STAT_OK;
                if (count_r == '0) begin
                  state_r <= S_FIN;
                end else if (method_r == METHOD_BINARY || method_r == METHOD_INTERP) begin
                  state_r <= S_PRE_HI;
                end else begin
                  state_r <= S_LIN_RD;
                end
              end
              default: begin
                res_status_r <= STAT_OK;
                state_r      <= S_FIN;
              end
            endcase
          end
        end

        // Insert: shift larger keys up one slot, then drop the new record in
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (key_lt) begin
            cur_r   <= cur_r - POS_ONE;
            state_r <= (cur_r > POS_ONE) ? S_INS_RD : S_INS_PUT;
          end else begin
            state_r <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          count_r   <= count_r + CW'(1);
          res_idx_r <= cur_r;
          state_r   <= S_FIN;
        end

        // Linear scan, first match
        S_LIN_RD: state_r <= S_LIN_CMP;
        S_LIN_CMP: begin
          if (key_eq) begin
            res_idx_r <= cur_r;
            res_pay_r <= (mode_r == MODE_LOOKUP) ? mem_rdata.payload : '0;
            state_r   <= (mode_r == MODE_LOOKUP) ? S_FIN : S_DEL_RD;
          end else if (cur_r + POS_ONE < n_s) begin
            cur_r   <= cur_r + POS_ONE;
            state_r <= S_LIN_RD;
          end else begin
            res_status_r <= STAT_NOT_FOUND;
            state_r      <= S_FIN;
          end
        end

        // Range precheck against first and last key
        S_PRE_HI: state_r <= S_PRE_LO;
        S_PRE_LO: begin
          khi_r   <= mem_rdata.key;
          state_r <= S_PRE_CHK;
        end
        S_PRE_CHK: begin
          if (key_r > khi_r || key_lt) begin
            res_status_r <= STAT_NOT_FOUND;
            state_r      <= S_FIN;
          end else if (method_r == METHOD_BINARY) begin
            lo_r    <= '0;
            hi_r    <= n_m1;
            cur_r   <= n_m1 >>> 1;
            state_r <= S_BIN_RD;
          end else begin
            left_r  <= '0;
            right_r <= n_m1;
            guard_r <= '0;
            state_r <= S_INT_WIN;
          end
        end

        // Binary search
        S_BIN_RD: state_r <= S_BIN_CMP;
        S_BIN_CMP: begin
          if (key_eq) begin
            res_idx_r <= cur_r;
            res_pay_r <= (mode_r == MODE_LOOKUP) ? mem_rdata.payload : '0;
            state_r   <= (mode_r == MODE_LOOKUP) ? S_FIN : S_DEL_RD;
          end else if (lo_nxt <= hi_nxt) begin
            lo_r    <= lo_nxt;
            hi_r    <= hi_nxt;
            cur_r   <= (lo_nxt + hi_nxt) >>> 1;
            state_r <= S_BIN_RD;
          end else begin
            res_status_r <= STAT_NOT_FOUND;
            state_r      <= S_FIN;
          end
        end

        // Interpolation search: one window per pass
        S_INT_WIN: begin
          if (guard_r == GW'(CAPACITY + 3)) begin
            res_status_r <= STAT_NOT_FOUND;
            state_r      <= S_FIN;
          end else begin
            guard_r <= guard_r + GW'(1);
            if (size_s <= WIN_SMALL) begin
              cur_r   <= left_r;
              state_r <= S_SCAN_RD;
            end else begin
              size_r  <= size_s[CW-1:0];
              state_r <= S_INT_RL;
            end
          end
        end
        S_INT_RL: state_r <= S_INT_RR;
        S_INT_RR: begin
          klo_r   <= mem_rdata.key;
          state_r <= S_INT_DIF;
        end
        S_INT_DIF: begin
          if (dvs_s == '0 || diff_s < 0) begin
            next_r  <= left_r;
            state_r <= S_INT_NRD;
          end else begin
            num_r   <= NW'(size_m1 * diff_s[31:0]);
            den_r   <= dvs_s[31:0];
            state_r <= S_INT_DIV;
          end
        end
        S_INT_DIV: state_r <= S_INT_DWT;
        S_INT_DWT: begin
          if (div_done) begin
            if (div_quo > NW'(size_m1)) begin
              next_r <= right_r;
            end else begin
              next_r <= left_r + $signed({{(SW-CW){1'b0}}, div_quo[CW-1:0]});
            end
            state_r <= S_INT_NRD;
          end
        end
        S_INT_NRD: state_r <= S_INT_NCMP;
        S_INT_NCMP: begin
          if (key_eq) begin
            cur_r     <= next_r;
            res_idx_r <= next_r;
            res_pay_r <= (mode_r == MODE_LOOKUP) ? mem_rdata.payload : '0;
            state_r   <= (mode_r == MODE_LOOKUP) ? S_FIN : S_DEL_RD;
          end else begin
            up_r    <= key_gt;
            i_r     <= IPW'(1);
            prev_r  <= '0;
            state_r <= S_STP_M1;
          end
        end

        // Jump steps of isqrt(i*i*size) away from the probe
        S_STP_M1: begin
          isq_r   <= (2*IPW)'(i_r * i_r);
          state_r <= S_STP_M2;
        end
        S_STP_M2: begin
          prod_r  <= (2*RW)'(isq_r * size_r);
          state_r <= S_STP_SQ;
        end
        S_STP_SQ: state_r <= S_STP_SW;
        S_STP_SW: begin
          if (sq_done) begin
            root_r  <= sq_root;
            temp_r  <= temp_nxt;
            state_r <= S_STP_RD;
          end
        end
        S_STP_RD: state_r <= S_STP_CMP;
        S_STP_CMP: begin
          if ((up_r ? key_gt : key_lt) && (IPW'(count_r) >= i_r)) begin
            i_r     <= i_r + IPW'(1);
            prev_r  <= root_r;
            state_r <= S_STP_M1;
          end else begin
            if (up_r) begin
              right_r <= temp_r;
              left_r  <= next_r + prev_s + POS_ONE;
            end else begin
              right_r <= next_r - prev_s - POS_ONE;
              left_r  <= temp_r;
            end
            state_r <= S_INT_WIN;
          end
        end

        // Small window: plain scan
        S_SCAN_RD: begin
          if (cur_r > right_r || cur_r >= n_s) begin
            res_status_r <= STAT_NOT_FOUND;
            state_r      <= S_FIN;
          end else begin
            state_r <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (key_eq) begin
            res_idx_r <= cur_r;
            res_pay_r <= (mode_r == MODE_LOOKUP) ? mem_rdata.payload : '0;
            state_r   <= (mode_r == MODE_LOOKUP) ? S_FIN : S_DEL_RD;
          end else begin
            cur_r   <= cur_r + POS_ONE;
            state_r <= S_SCAN_RD;
          end
        end

        // Delete: pull later records down one slot
        S_DEL_RD: begin
          if (cur_r + POS_ONE < n_s) begin
            state_r <= S_DEL_WR;
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= S_FIN;
          end
        end
        S_DEL_WR: begin
          cur_r   <= cur_r + POS_ONE;
          state_r <= S_DEL_RD;
        end

        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tuser_r <= res_status_r;
            out_tdata_r <= {7'b0, cnt_w[8:0], res_pay_r, idx_w[7:0]};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ($past(state_r) == S_INS_PUT || $past(state_r) == S_DEL_RD))
    else $error("entry count changed outside insert or delete");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r == STAT_FULL) |-> count_r == CW'(CAPACITY))
    else $error("full status with room left");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("finished result not presented");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.wr |-> (mem_cmd.addr < ADDR_W'(CAPACITY)))
    else $error("memory write outside table");

endmodule

[rtl/sorted_key_table_search.sv]
// Sorted key table: up to CAPACITY records (signed 32-bit key, 32-bit payload)
// kept in ascending key order in one single-port memory, accessed one word per
// cycle. Insert shifts each record with a larger key up one slot; delete searches,
// then pulls each later record down one slot; lookup is a search. Searches:
// linear probes one entry at a time; binary runs a range check against the
// first and last key, then probes; interpolation runs the range check, then per
// window a probe from the serial divider (NW = clog2(CAPACITY+1)+32), then jump
// steps sized by the serial square root, or a plain scan of a window of five or
// fewer. A finished result is held in an output register while the next
// transaction is taken. No clearing pass runs after reset; record data is only
// used below the entry count.
// Depends on skts_pkg, skts_ram, skts_div, skts_isqrt and skts_ctrl.
module sorted_key_table_search #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[31:0], payload_in[63:32]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // found_index[7:0], payload_out[39:8],
                                  // count_now[48:40], zero fill[55:49]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata   // search_method
);
  import skts_pkg::*;

  // Widths of the counters, the probe arithmetic and the serial units
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IPW = CW + 1;
  localparam int SQW = 2 * IPW + CW;
  localparam int RW  = (SQW + 1) / 2;
  localparam int NW  = CW + 32;

  mem_cmd_t        mem_cmd;
  mem_word_t       mem_rdata;
  logic            div_start;
  logic [NW-1:0]   div_num;
  logic [31:0]     div_den;
  logic            div_done;
  logic [NW-1:0]   div_quo;
  logic            sq_start;
  logic [2*RW-1:0] sq_val;
  logic            sq_done;
  logic [RW-1:0]   sq_root;

  // Record memory
  skts_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rdata_r (mem_rdata)
  );

  // Interpolation probe divider
  skts_div #(.NW(NW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quo    (div_quo)
  );

  // Jump-step square root
  skts_isqrt #(.RW(RW)) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .val    (sq_val),
    .done_r (sq_done),
    .root_r (sq_root)
  );

  // Sequencer for insert, delete, lookup and the three search methods
  skts_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .NW       (NW),
    .RW       (RW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mem_cmd    (mem_cmd),
    .mem_rdata  (mem_rdata),
    .div_start  (div_start),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_done   (div_done),
    .div_quo    (div_quo),
    .sq_start   (sq_start),
    .sq_val     (sq_val),
    .sq_done    (sq_done),
    .sq_root    (sq_root)
  );

endmodule
